/* rtl/ewds_pkg.sv */
// ----------------------------------------------------------------------------
// ewds_pkg
// Shared types, codes and the interval base table of the watchdog supervisor.
// ----------------------------------------------------------------------------
package ewds_pkg;

	localparam int ELAPSED_BITS_DEF = 12;
	localparam int QUEUE_DEPTH      = 2;

	localparam int CFG_W      = 16;
	localparam int BASE_W     = 7;
	localparam int MULT_W     = 5;
	localparam int VALUE_W    = 16;
	localparam int BASE_COUNT = 7;

	localparam logic [BASE_W-1:0] BASE_RESET = 7'd15;
	localparam logic [MULT_W-1:0] MULT_RESET = 5'd8;
	localparam logic [CFG_W-1:0]  VERSION_RESET = 16'd130;
	localparam logic [CFG_W-1:0]  DATE_RESET    = 16'd147;

	// configuration register indexes
	localparam logic REG_VERSION = 1'b0;
	localparam logic REG_DATE    = 1'b1;

	// command codes
	localparam logic [7:0] CMD_PING      = 8'd0;
	localparam logic [7:0] CMD_UNLOCK    = 8'd1;
	localparam logic [7:0] CMD_LOCK      = 8'd2;
	localparam logic [7:0] CMD_VERSION   = 8'd3;
	localparam logic [7:0] CMD_DATE      = 8'd4;
	localparam logic [7:0] CMD_REBOOT    = 8'd6;
	localparam logic [7:0] CMD_TOGGLE    = 8'd7;
	localparam logic [7:0] CMD_ENABLE    = 8'd10;
	localparam logic [7:0] CMD_DISABLE   = 8'd11;
	localparam logic [7:0] CMD_HEARTBEAT = 8'd12;
	localparam logic [7:0] CMD_BASE_LO   = 8'd20;
	localparam logic [7:0] CMD_BASE_HI   = 8'd29;
	localparam logic [7:0] CMD_MULT_LO   = 8'd30;
	localparam logic [7:0] CMD_MULT_HI   = 8'd49;
	localparam logic [7:0] CMD_MULT_OFS  = 8'd29;

	// response kinds
	localparam logic [2:0] RK_SUCCESS = 3'd0;
	localparam logic [2:0] RK_ERROR   = 3'd1;
	localparam logic [2:0] RK_WARNING = 3'd2;
	localparam logic [2:0] RK_PING    = 3'd3;
	localparam logic [2:0] RK_LOCKED  = 3'd4;
	localparam logic [2:0] RK_VALUE   = 3'd5;

	localparam logic ACT_BUS   = 1'b0;
	localparam logic ACT_POWER = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] command_byte;
	} in_item_t;

	typedef struct packed {
		logic               action;
		logic [2:0]         response_kind;
		logic [VALUE_W-1:0] response_value;
		logic               pin_output_mode;
		logic               monitoring_on;
		logic               last;
	} out_item_t;

	// one queued job: a single bus response, or a warning plus power cycle
	typedef struct packed {
		logic               dbl;
		logic [2:0]         rkind;
		logic [VALUE_W-1:0] value;
		logic               pin;
		logic               mon;
	} job_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_stat_t;

	function automatic logic [BASE_W-1:0] base_lookup(input logic [2:0] sel);
		logic [BASE_W-1:0] v;
		unique case (sel)
			3'd0: v = 7'd1;
			3'd1: v = 7'd5;
			3'd2: v = 7'd10;
			3'd3: v = 7'd15;
			3'd4: v = 7'd30;
			3'd5: v = 7'd60;
			3'd6: v = 7'd90;
			default: v = 7'd1;
		endcase
		return v;
	endfunction

endpackage

/* rtl/external_watchdog_supervisor_top.sv */
// ----------------------------------------------------------------------------
// external_watchdog_supervisor_top
// Watchdog supervisor for a primary processor: bus commands, second ticks,
// timeout warning and power-cycle request.
// ----------------------------------------------------------------------------
// The front accepts one command byte or tick per cycle unless the queue is
// full, updates the supervisor state at the transfer and places any
// response job in a two-entry queue; the back turns each job into result
// transfers through a registered output. A command with one response
// sustains one item per cycle unless the output stalls; a reboot command or
// a timeout tick gives a warning and then a power-cycle transfer, so it
// holds the output register for both transfers. Items that give no
// response (toggle, ignored codes, idle ticks) never reach the queue.
// Input stall rises only when the queue is full. The version and date
// registers are written through cfg_we.
// ----------------------------------------------------------------------------
module external_watchdog_supervisor_top #(
	parameter int ELAPSED_BITS = ewds_pkg::ELAPSED_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ewds_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ewds_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ewds_pkg::CFG_W-1:0] cfg_data
);
	import ewds_pkg::*;

	queue_stat_t q_stat;
	logic        push, pop;
	job_t        push_job, pop_job;

	ewds_front #(
		.ELAPSED_BITS(ELAPSED_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	ewds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.q_stat  (q_stat)
	);

	ewds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_job  (pop_job),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

/* rtl/ewds_front.sv */
// ----------------------------------------------------------------------------
// ewds_front
// Accepts commands and ticks, updates supervisor state and queues the jobs.
// ----------------------------------------------------------------------------
module ewds_front #(
	parameter int ELAPSED_BITS = ewds_pkg::ELAPSED_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ewds_pkg::in_item_t            in_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [ewds_pkg::CFG_W-1:0]    cfg_data,
	input  ewds_pkg::queue_stat_t         q_stat,
	output logic                          push,
	output ewds_pkg::job_t                push_job
);
	import ewds_pkg::*;

	localparam int PROD_W = BASE_W + MULT_W;
	localparam int CMP_W  = (ELAPSED_BITS > PROD_W) ? ELAPSED_BITS : PROD_W;

	logic [CFG_W-1:0]        version_q, date_q;
	logic                    mon_q, open_q, pin_q;
	logic [BASE_W-1:0]       base_q;
	logic [MULT_W-1:0]       mult_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;

	logic                    mon_n, open_n, pin_n;
	logic [BASE_W-1:0]       base_n;
	logic [MULT_W-1:0]       mult_n;
	logic [ELAPSED_BITS-1:0] elapsed_n, elapsed_inc;
	logic [PROD_W-1:0]       limit;
	logic                    timed_out, accept, do_push;
	job_t                    job;
	logic [7:0]              cmd;
	logic [7:0]              sel;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign cmd      = in_data.command_byte;
	assign sel      = cmd - CMD_BASE_LO;

	assign limit       = PROD_W'(base_q) * PROD_W'(mult_q);
	assign elapsed_inc = (elapsed_q == {ELAPSED_BITS{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign timed_out   = mon_q && (CMP_W'(elapsed_q) > CMP_W'(limit));

	always_comb begin
		mon_n     = mon_q;
		open_n    = open_q;
		pin_n     = pin_q;
		base_n    = base_q;
		mult_n    = mult_q;
		elapsed_n = elapsed_q;
		do_push   = 1'b0;
		job.dbl   = 1'b0;
		job.rkind = RK_SUCCESS;
		job.value = '0;
		if (in_data.kind) begin
			if (mon_q) begin
				if (CMP_W'(elapsed_inc) > CMP_W'(limit)) begin
					mon_n     = 1'b0;
					elapsed_n = '0;
					open_n    = 1'b0;
					do_push   = 1'b1;
					job.dbl   = 1'b1;
				end else begin
					elapsed_n = elapsed_inc;
				end
			end
		end else if (!timed_out) begin
			unique case (cmd)
				CMD_PING: begin
					do_push   = 1'b1;
					job.rkind = RK_PING;
				end
				CMD_UNLOCK: begin
					open_n  = 1'b1;
					do_push = 1'b1;
				end
				CMD_LOCK: begin
					open_n  = 1'b0;
					do_push = 1'b1;
				end
				CMD_VERSION: begin
					do_push   = 1'b1;
					job.rkind = RK_VALUE;
					job.value = version_q;
				end
				CMD_DATE: begin
					do_push   = 1'b1;
					job.rkind = RK_VALUE;
					job.value = date_q;
				end
				CMD_REBOOT: begin
					do_push = 1'b1;
					job.dbl = 1'b1;
				end
				CMD_TOGGLE: begin
					pin_n = !pin_q;
				end
				CMD_ENABLE: begin
					if (!mon_q) begin
						mon_n     = 1'b1;
						elapsed_n = '0;
						open_n    = 1'b0;
						do_push   = 1'b1;
					end
				end
				CMD_DISABLE: begin
					if (mon_q) begin
						mon_n     = 1'b0;
						elapsed_n = '0;
						open_n    = 1'b0;
						do_push   = 1'b1;
					end
				end
				CMD_HEARTBEAT: begin
					if (mon_q) begin
						elapsed_n = '0;
						open_n    = 1'b0;
						do_push   = 1'b1;
					end
				end
				default: begin
					if (cmd >= CMD_BASE_LO && cmd <= CMD_BASE_HI) begin
						do_push = 1'b1;
						if (!open_q) begin
							job.rkind = RK_LOCKED;
						end else if (sel < 8'(BASE_COUNT)) begin
							base_n    = base_lookup(sel[2:0]);
							job.rkind = RK_VALUE;
							job.value = VALUE_W'(base_n);
						end else begin
							job.rkind = RK_ERROR;
						end
					end else if (cmd >= CMD_MULT_LO && cmd <= CMD_MULT_HI) begin
						do_push = 1'b1;
						if (!open_q) begin
							job.rkind = RK_LOCKED;
						end else begin
							mult_n    = MULT_W'(cmd - CMD_MULT_OFS);
							job.rkind = RK_VALUE;
							job.value = VALUE_W'(mult_n);
						end
					end
				end
			endcase
		end
		job.pin = pin_n;
		job.mon = mon_n;
	end

	assign push     = accept && do_push;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
			date_q    <= DATE_RESET;
			mon_q     <= 1'b0;
			open_q    <= 1'b0;
			pin_q     <= 1'b0;
			base_q    <= BASE_RESET;
			mult_q    <= MULT_RESET;
			elapsed_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VERSION: version_q <= cfg_data;
					REG_DATE:    date_q    <= cfg_data;
					default:     ;
				endcase
			end
			if (accept) begin
				mon_q     <= mon_n;
				open_q    <= open_n;
				pin_q     <= pin_n;
				base_q    <= base_n;
				mult_q    <= mult_n;
				elapsed_q <= elapsed_n;
			end
		end
	end

endmodule

/* rtl/ewds_queue.sv */
// ----------------------------------------------------------------------------
// ewds_queue
// Short job queue between the command front and the response back.
// ----------------------------------------------------------------------------
module ewds_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ewds_pkg::job_t        push_job,
	input  logic                  pop,
	output ewds_pkg::job_t        pop_job,
	output ewds_pkg::queue_stat_t q_stat
);
	import ewds_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.not_empty = (count_q != '0);
	assign do_push          = push && !q_stat.full;
	assign do_pop           = pop && q_stat.not_empty;
	assign pop_job          = slot_q[rd_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/ewds_back.sv */
// ----------------------------------------------------------------------------
// ewds_back
// Expands queued jobs into result transfers through an output register.
// ----------------------------------------------------------------------------
module ewds_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ewds_pkg::queue_stat_t q_stat,
	input  ewds_pkg::job_t        pop_job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ewds_pkg::out_item_t   out_data
);
	import ewds_pkg::*;

	logic      out_valid_q, second_q, hold_pin_q, hold_mon_q;
	out_item_t out_q;
	logic      advance;

	assign advance   = !out_valid_q || !out_stall;
	assign pop       = advance && !second_q && q_stat.not_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (second_q) begin
				out_q.action          <= ACT_POWER;
				out_q.response_kind   <= RK_SUCCESS;
				out_q.response_value  <= '0;
				out_q.pin_output_mode <= hold_pin_q;
				out_q.monitoring_on   <= hold_mon_q;
				out_q.last            <= 1'b1;
			end else if (q_stat.not_empty) begin
				out_q.action          <= ACT_BUS;
				out_q.response_kind   <= pop_job.dbl ? RK_WARNING : pop_job.rkind;
				out_q.response_value  <= pop_job.dbl ? '0 : pop_job.value;
				out_q.pin_output_mode <= pop_job.pin;
				out_q.monitoring_on   <= pop_job.mon;
				out_q.last            <= !pop_job.dbl;
				hold_pin_q            <= pop_job.pin;
				hold_mon_q            <= pop_job.mon;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (advance) begin
			if (second_q) begin
				// power-cycle transfer follows the warning
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else if (q_stat.not_empty) begin
				out_valid_q <= 1'b1;
				second_q    <= pop_job.dbl;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
